// File: rtl/pfsl_pkg.sv
`timescale 1ns / 1ps

package pfsl_pkg;

	// Panel geometry
	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;

	// Frame store in page layout: byte index = x + (y/8)*PAGE_STRIDE, bit y%8
	localparam int STORE_DEPTH = 1024;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int PAGE_STRIDE = 128;
	localparam int COL_W       = $clog2(PAGE_STRIDE);
	localparam int PAGE_W      = STORE_AW - COL_W;

	// Serial framing
	localparam logic [7:0] SYNC_CMD  = 8'hF8;
	localparam logic [7:0] SYNC_DATA = 8'hFA;
	localparam int FETCH_LEN  = 12;
	localparam int BEAT_W     = $clog2(FETCH_LEN);
	localparam int WORD_BITS  = 16;
	localparam int WORD_CNT_W = $clog2(WORD_BITS) + 1;

	typedef enum logic [1:0] {
		FUNC_SET   = 2'd0,
		FUNC_CLR   = 2'd1,
		FUNC_FETCH = 2'd2,
		FUNC_WIPE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_WIPE,
		ST_IDLE,
		ST_PIXEL,
		ST_FETCH
	} state_t;

endpackage

// File: rtl/pfsl_in_if.sv
`timescale 1ns / 1ps

interface pfsl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] x;
	logic [7:0] y;

	modport source (output valid, func, x, y, input ready);
	modport sink   (input valid, func, x, y, output ready);
endinterface

// File: rtl/pfsl_out_if.sv
`timescale 1ns / 1ps

interface pfsl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] serial_byte;
	logic       last;

	modport source (output valid, serial_byte, last, input ready);
	modport sink   (input valid, serial_byte, last, output ready);
endinterface

// File: rtl/page_framebuffer_serial_lcd_flush.sv
`timescale 1ns / 1ps

// Monochrome 128x64 frame store with a serial LCD row writer.
//
// cmd (sink): one beat per operation, func/x/y. Set pixel, clear pixel,
//   fetch one 16-pixel row word, or wipe the whole store. Pixels outside
//   the panel are dropped; an out-of-range fetch produces no beats.
// lcd (source): twelve beats per fetch: row command, column command and
//   two transposed data bytes, each framed as sync, high nibble, low nibble.
//   last marks the twelfth beat.
//
// Timing: a set or clear reads its byte as the command is accepted, then
//   writes it back in the PIXEL state. A fetch streams the six command beats
//   at once while 16 store bytes are read one per cycle; data beats start once
//   all 16 are gathered. The store has one read and one write port.
// Reset and wipe: the store is swept to zero, one byte per cycle; cmd.ready
//   stays low meanwhile.
// Stalls: while lcd.ready is low the current beat holds; store reads of a
//   fetch continue underneath. No new command is taken until the fetch ends.
module page_framebuffer_serial_lcd_flush (
	input  logic              clk,
	input  logic              arst_n,
	pfsl_in_if.sink           cmd,
	pfsl_out_if.source        lcd
);

	pfsl_pkg::state_t state_q, state_d;

	logic [pfsl_pkg::STORE_AW-1:0]   wipe_cnt_q;
	logic [pfsl_pkg::BEAT_W-1:0]     beat_q;
	logic [pfsl_pkg::WORD_CNT_W-1:0] rd_cnt_q;
	logic [pfsl_pkg::WORD_CNT_W-1:0] gath_cnt_q;
	logic                            rd_vld_s1;

	// Item payload held for the operation in flight
	logic [5:0]                   row_q;
	logic [pfsl_pkg::COL_W-1:0]   col_q;
	logic                         set_q;
	logic [pfsl_pkg::WORD_BITS-1:0] gather_q;

	// Frame store
	logic [7:0] mem [pfsl_pkg::STORE_DEPTH];
	logic [7:0] rd_data_q;

	logic                          wr_en, rd_en;
	logic [pfsl_pkg::STORE_AW-1:0] wr_addr, rd_addr;
	logic [7:0]                    wr_data;

	logic cmd_fire, lcd_fire, in_range, fetch_rd, gathered, wipe_done;
	logic [7:0] row_cmd, col_cmd, bit_mask;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign lcd_fire  = lcd.valid && lcd.ready;
	assign in_range  = ({1'b0, cmd.x} < 9'(pfsl_pkg::DISPLAY_WIDTH))
		&& ({1'b0, cmd.y} < 9'(pfsl_pkg::DISPLAY_HEIGHT));
	assign fetch_rd  = (state_q == pfsl_pkg::ST_FETCH)
		&& (rd_cnt_q < pfsl_pkg::WORD_CNT_W'(pfsl_pkg::WORD_BITS));
	assign gathered  = gath_cnt_q == pfsl_pkg::WORD_CNT_W'(pfsl_pkg::WORD_BITS);
	assign wipe_done = wipe_cnt_q == pfsl_pkg::STORE_AW'(pfsl_pkg::STORE_DEPTH - 1);

	// Upper half of the panel reuses row addresses 0..31 with column base 0x88
	assign row_cmd  = {3'b100, row_q[4:0]};
	assign col_cmd  = {4'b1000, row_q[5], col_q[6:4]};
	assign bit_mask = 8'(1) << row_q[2:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfsl_pkg::ST_WIPE: begin
				if (wipe_done) state_d = pfsl_pkg::ST_IDLE;
			end
			pfsl_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					priority if (pfsl_pkg::func_t'(cmd.func) == pfsl_pkg::FUNC_WIPE)
						state_d = pfsl_pkg::ST_WIPE;
					else if (!in_range)
						state_d = pfsl_pkg::ST_IDLE;
					else if (pfsl_pkg::func_t'(cmd.func) == pfsl_pkg::FUNC_FETCH)
						state_d = pfsl_pkg::ST_FETCH;
					else
						state_d = pfsl_pkg::ST_PIXEL;
				end
			end
			pfsl_pkg::ST_PIXEL: state_d = pfsl_pkg::ST_IDLE;
			pfsl_pkg::ST_FETCH: begin
				if (lcd_fire && lcd.last) state_d = pfsl_pkg::ST_IDLE;
			end
			default: state_d = pfsl_pkg::ST_IDLE;
		endcase
	end

	// Outputs and store port control
	always_comb begin
		cmd.ready = 1'b0;
		lcd.valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = wipe_cnt_q;
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = {row_q[5:3], col_q[6:4], rd_cnt_q[3:0]};
		unique case (state_q)
			pfsl_pkg::ST_WIPE: begin
				wr_en = 1'b1;
			end
			pfsl_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				// read ahead for a pixel update; harmless for other items
				rd_en   = 1'b1;
				rd_addr = {cmd.y[5:3], cmd.x[6:0]};
			end
			pfsl_pkg::ST_PIXEL: begin
				wr_en   = 1'b1;
				wr_addr = {row_q[5:3], col_q};
				wr_data = set_q ? (rd_data_q | bit_mask) : (rd_data_q & ~bit_mask);
			end
			pfsl_pkg::ST_FETCH: begin
				rd_en     = fetch_rd;
				// command beats go out at once; data beats wait for the gather
				lcd.valid = (beat_q < pfsl_pkg::BEAT_W'(6)) || gathered;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (beat_q)
			4'd0, 4'd3: lcd.serial_byte = pfsl_pkg::SYNC_CMD;
			4'd1:       lcd.serial_byte = {row_cmd[7:4], 4'h0};
			4'd2:       lcd.serial_byte = {row_cmd[3:0], 4'h0};
			4'd4:       lcd.serial_byte = {col_cmd[7:4], 4'h0};
			4'd5:       lcd.serial_byte = {col_cmd[3:0], 4'h0};
			4'd6, 4'd9: lcd.serial_byte = pfsl_pkg::SYNC_DATA;
			4'd7:       lcd.serial_byte = {gather_q[15:12], 4'h0};
			4'd8:       lcd.serial_byte = {gather_q[11:8], 4'h0};
			4'd10:      lcd.serial_byte = {gather_q[7:4], 4'h0};
			4'd11:      lcd.serial_byte = {gather_q[3:0], 4'h0};
			default:    lcd.serial_byte = '0;
		endcase
	end
	assign lcd.last = beat_q == pfsl_pkg::BEAT_W'(pfsl_pkg::FETCH_LEN - 1);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfsl_pkg::ST_WIPE;
			wipe_cnt_q <= '0;
			beat_q     <= '0;
			rd_cnt_q   <= '0;
			gath_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= fetch_rd;
			if (state_q == pfsl_pkg::ST_WIPE)
				wipe_cnt_q <= wipe_cnt_q + 1'b1;
			if (cmd_fire) begin
				// restart sweep, beat and gather counters for the new item
				wipe_cnt_q <= '0;
				beat_q     <= '0;
				rd_cnt_q   <= '0;
				gath_cnt_q <= '0;
			end else begin
				if (fetch_rd) rd_cnt_q <= rd_cnt_q + 1'b1;
				if (rd_vld_s1) gath_cnt_q <= gath_cnt_q + 1'b1;
				if (lcd_fire) beat_q <= beat_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			row_q <= cmd.y[5:0];
			col_q <= cmd.x[6:0];
			set_q <= pfsl_pkg::func_t'(cmd.func) == pfsl_pkg::FUNC_SET;
		end
		// leftmost column lands in the msb of the first data byte
		if (rd_vld_s1)
			gather_q <= {gather_q[pfsl_pkg::WORD_BITS-2:0], rd_data_q[row_q[2:0]]};
	end

	// Store ports
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

`ifndef ASSERT_OFF
	a_last_ends_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		lcd_fire && lcd.last |=> state_q == pfsl_pkg::ST_IDLE)
		else $error("fetch did not end after its last beat");

	a_data_after_gather: assert property (@(posedge clk) disable iff (!arst_n)
		lcd.valid && (beat_q >= pfsl_pkg::BEAT_W'(6)) |-> gathered)
		else $error("data beat offered before the row word was gathered");

	a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfsl_pkg::ST_FETCH |-> !wr_en)
		else $error("store written during a fetch");

	a_pixel_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfsl_pkg::ST_PIXEL |-> $past(rd_en) && $past(cmd_fire))
		else $error("pixel write-back without a preceding read");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

	// Command bytes that the row writer puts in front of the data
	localparam logic [7:0] ROW_CMD_BASE  = 8'h80;
	localparam logic [7:0] COL_CMD_LOWER = 8'h80;
	localparam logic [7:0] COL_CMD_UPPER = 8'h88;
	localparam int         HALF_ROWS     = 32;
	localparam int         STALL_PCT     = 12;
	// A wipe sweeps the store with no handshake at all
	localparam int         WATCHDOG_MAX  = 4000;
	localparam int         DRAIN_CYCLES  = 40;
	localparam int         RANDOM_CMDS   = 206;

	typedef struct {
		logic [7:0] serial_byte;
		logic       last;
	} lcd_beat_t;

	// Shadow frame store plus the stream of LCD beats still owed by the block
	class lcd_stream_model;
		logic [7:0]  pixels [pfsl_pkg::STORE_DEPTH];
		lcd_beat_t   lcd_expected [$];
		int unsigned fails;

		function new();
			fails = 0;
			wipe_store();
		endfunction

		function void wipe_store();
			foreach (pixels[i])
				pixels[i] = 8'h00;
		endfunction

		// One command or data byte goes out as sync, high nibble, low nibble
		function void push_framed(logic [7:0] sync, logic [7:0] b, bit fin);
			lcd_beat_t bt;
			bt.serial_byte = sync;
			bt.last = 1'b0;
			lcd_expected.push_back(bt);
			bt.serial_byte = {b[7:4], 4'h0};
			lcd_expected.push_back(bt);
			bt.serial_byte = {b[3:0], 4'h0};
			bt.last = fin;
			lcd_expected.push_back(bt);
		endfunction

		function void apply_cmd(pfsl_pkg::func_t f, logic [7:0] px, logic [7:0] py);
			int unsigned idx;
			int unsigned base;
			logic [2:0]  grp;
			logic [2:0]  bitpos;
			logic [7:0]  row_cmd;
			logic [7:0]  col_cmd;
			logic [7:0]  data [2];
			if (f == pfsl_pkg::FUNC_WIPE) begin
				wipe_store();
				return;
			end
			// Drop anything that falls off the panel
			if (px >= pfsl_pkg::DISPLAY_WIDTH || py >= pfsl_pkg::DISPLAY_HEIGHT)
				return;
			bitpos = py[2:0];
			idx = (px + (py / 8) * pfsl_pkg::PAGE_STRIDE) % pfsl_pkg::STORE_DEPTH;
			case (f)
				pfsl_pkg::FUNC_SET: pixels[idx][bitpos] = 1'b1;
				pfsl_pkg::FUNC_CLR: pixels[idx][bitpos] = 1'b0;
				default: begin
					grp = px[6:4];
					if (py < HALF_ROWS) begin
						row_cmd = ROW_CMD_BASE | py;
						col_cmd = COL_CMD_LOWER | {5'd0, grp};
					end else begin
						row_cmd = ROW_CMD_BASE | 8'(py - HALF_ROWS);
						col_cmd = COL_CMD_UPPER | {5'd0, grp};
					end
					// Transpose: leftmost column lands in the msb
					base = (py / 8) * pfsl_pkg::PAGE_STRIDE + grp * 16;
					for (int k = 0; k < 2; k++)
						for (int i = 0; i < 8; i++)
							data[k][7 - i] =
								pixels[(base + k * 8 + i) % pfsl_pkg::STORE_DEPTH][bitpos];
					push_framed(pfsl_pkg::SYNC_CMD, row_cmd, 1'b0);
					push_framed(pfsl_pkg::SYNC_CMD, col_cmd, 1'b0);
					push_framed(pfsl_pkg::SYNC_DATA, data[0], 1'b0);
					push_framed(pfsl_pkg::SYNC_DATA, data[1], 1'b1);
				end
			endcase
		endfunction

		function void check_beat(logic [7:0] sbyte, logic lst);
			lcd_beat_t want;
			if (lcd_expected.size() == 0) begin
				$error("unexpected lcd beat: serial_byte %h last %b", sbyte, lst);
				fails++;
				return;
			end
			want = lcd_expected.pop_front();
			if (sbyte !== want.serial_byte) begin
				$error("serial_byte: expected %h, actual %h", want.serial_byte, sbyte);
				fails++;
			end
			if (lst !== want.last) begin
				$error("last: expected %b, actual %b", want.last, lst);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	// Set during the stretch where neither side is allowed to stall
	bit   steady;
	int   quiet_cycles = 0;

	pfsl_in_if  cmd_if ();
	pfsl_out_if lcd_if ();

	lcd_stream_model lcd_pred = new();

	page_framebuffer_serial_lcd_flush uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if.sink),
		.lcd    (lcd_if.source)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Sink side: hold off lcd.ready now and then, unless in the steady stretch
	always @(posedge clk) begin
		lcd_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
	end

	// Watch both channels at the edge; values read here are the pre-edge ones,
	// so the RTL's own updates at this edge cannot leak in.
	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready)
			lcd_pred.apply_cmd(pfsl_pkg::func_t'(cmd_if.func), cmd_if.x, cmd_if.y);
		if (arst_n && lcd_if.valid && lcd_if.ready)
			lcd_pred.check_beat(lcd_if.serial_byte, lcd_if.last);
	end

	// Watchdog: count cycles with no beat on either channel
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (lcd_if.valid && lcd_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("[page_framebuffer_serial_lcd_flush] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one command beat and hold it until the block takes it. Idle
	// cycles go in front; valid is only ever written once per edge.
	task automatic send_cmd(pfsl_pkg::func_t f, logic [7:0] px, logic [7:0] py);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.func  <= f;
		cmd_if.x     <= px;
		cmd_if.y     <= py;
		do
			@(posedge clk);
		while (!cmd_if.ready);
	endtask

	// Random traffic. Pixel writes and fetches cluster on one hot word group
	// so that fetched words carry real content; the group moves now and then.
	task automatic run_random();
		logic [2:0] hot_grp;
		logic [7:0] px;
		logic [7:0] py;
		int         r;
		hot_grp = 3'($urandom_range(7));
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			steady = (n >= 80 && n < 140);
			if (n % 50 == 0)
				hot_grp = 3'($urandom_range(7));
			r  = $urandom_range(99);
			py = 8'($urandom_range(pfsl_pkg::DISPLAY_HEIGHT - 1));
			if ($urandom_range(1))
				px = {1'b0, hot_grp, 4'($urandom_range(15))};
			else
				px = 8'($urandom_range(pfsl_pkg::DISPLAY_WIDTH - 1));
			if (r < 2) begin
				send_cmd(pfsl_pkg::FUNC_WIPE, 8'($urandom_range(255)),
					8'($urandom_range(255)));
			end else if (r < 7) begin
				// Off-panel noise: force at least one coordinate out of range
				px = 8'($urandom_range(255));
				py = 8'($urandom_range(255));
				if (px < pfsl_pkg::DISPLAY_WIDTH && py < pfsl_pkg::DISPLAY_HEIGHT)
					px[7] = 1'b1;
				send_cmd(pfsl_pkg::func_t'($urandom_range(2)), px, py);
			end else if (r < 38) begin
				send_cmd(pfsl_pkg::FUNC_FETCH, px, py);
			end else if (r < 52) begin
				send_cmd(pfsl_pkg::FUNC_CLR, px, py);
			end else begin
				send_cmd(pfsl_pkg::FUNC_SET, px, py);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		steady        = 1'b0;
		arst_n        <= 1'b0;
		cmd_if.valid  <= 1'b0;
		cmd_if.func   <= pfsl_pkg::FUNC_SET;
		cmd_if.x      <= 8'd0;
		cmd_if.y      <= 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: panel corners, word groups at both ends, the row split at
		// 32, off-panel writes and fetches, and a fetch after a wipe.
		send_cmd(pfsl_pkg::FUNC_SET,   8'd0,   8'd0);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd127, 8'd63);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd127, 8'd0);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd0,   8'd63);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd128, 8'd5);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd5,   8'd64);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd0,   8'd0);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd127, 8'd63);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd112, 8'd0);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd0,   8'd63);
		send_cmd(pfsl_pkg::FUNC_CLR,   8'd0,   8'd0);
		send_cmd(pfsl_pkg::FUNC_CLR,   8'd200, 8'd200);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd0,   8'd0);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd128, 8'd0);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd0,   8'd64);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd255, 8'd255);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd8,   8'd31);
		send_cmd(pfsl_pkg::FUNC_SET,   8'd8,   8'd32);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd8,   8'd31);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd8,   8'd32);
		send_cmd(pfsl_pkg::FUNC_CLR,   8'd127, 8'd63);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd120, 8'd63);
		send_cmd(pfsl_pkg::FUNC_WIPE,  8'd255, 8'd255);
		send_cmd(pfsl_pkg::FUNC_FETCH, 8'd0,   8'd63);

		run_random();

		cmd_if.valid <= 1'b0;
		// Drain: wait for every owed beat, then a little longer for strays
		while (lcd_pred.lcd_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (lcd_pred.fails == 0 && lcd_pred.lcd_expected.size() == 0) begin
			$display("[page_framebuffer_serial_lcd_flush] OK");
		end else begin
			$display("[page_framebuffer_serial_lcd_flush] ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/pfsl_pkg.sv
rtl/pfsl_in_if.sv
rtl/pfsl_out_if.sv
rtl/page_framebuffer_serial_lcd_flush.sv
dv/tb.sv
